>>> design/lgrs_pkg.sv
package lgrs_pkg;

	// Width of a row on the stream ports.
	localparam int ROW_BITS = 64;

	// Width of the row_width register and its value after reset.
	localparam int WIDTH_BITS = 7;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

	// Neighbour counts that give a live cell in the next generation.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT = 4'd2;

	// Result queue.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int LVL_W = 3;

	// Bits that one column shows to the columns on either side, already masked.
	typedef struct packed {
		logic up;
		logic pend;
		logic cur;
	} nb_t;

	// One result item.
	typedef struct packed {
		logic [ROW_BITS-1:0] cells;
		logic last;
	} result_t;

	// Up to two results written into the queue in one cycle, in order.
	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

	// Queue status seen by the top level.
	typedef struct packed {
		logic [LVL_W-1:0] level;
	} queue_stat_t;

endpackage

>>> design/lgrs_cell.sv
module lgrs_cell
	import lgrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic col_en,
	input  logic in_bit,
	input  logic acc,
	input  logic last,
	input  logic held,
	input  nb_t  nb_left,
	input  nb_t  nb_right,
	output nb_t  nb_own,
	output logic res_mid,
	output logic res_last
);

	logic upper_q;
	logic pend_q;
	logic u, p, i;
	logic a_own, a_left, a_right;
	logic [3:0] cnt_mid;
	logic [3:0] cnt_last;

	assign u = upper_q & col_en;
	assign p = pend_q & col_en;
	assign i = in_bit & col_en;

	assign nb_own = '{up: u, pend: p, cur: i};

	// Row above, this row's pending bit and the incoming row below.
	assign cnt_mid = 4'(nb_left.up) + 4'(nb_left.pend) + 4'(nb_left.cur)
		+ 4'(nb_right.up) + 4'(nb_right.pend) + 4'(nb_right.cur)
		+ 4'(u) + 4'(i);
	assign res_mid = col_en & ((cnt_mid == BIRTH_COUNT) | (p & (cnt_mid == KEEP_COUNT)));

	// Bottom row: the pending row moves up (if any), the incoming row is the
	// middle, and a dead row lies below.
	assign a_own = held & p;
	assign a_left = held & nb_left.pend;
	assign a_right = held & nb_right.pend;
	assign cnt_last = 4'(a_left) + 4'(nb_left.cur) + 4'(a_right) + 4'(nb_right.cur)
		+ 4'(a_own);
	assign res_last = col_en & ((cnt_last == BIRTH_COUNT) | (i & (cnt_last == KEEP_COUNT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				upper_q <= 1'b0;
				pend_q <= 1'b0;
			end else begin
				upper_q <= a_own;
				pend_q <= i;
			end
		end
	end

endmodule

>>> design/lgrs_out_queue.sv
module lgrs_out_queue
	import lgrs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  push_t               push,
	input  logic                pop,
	output result_t             head,
	output logic                not_empty,
	output queue_stat_t         stat
);

	result_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [PTR_W-1:0] wr_next;
	logic do_pop;

	assign wr_next = wr_ptr_q + PTR_W'(1);
	assign not_empty = (level_q != '0);
	assign do_pop = pop & not_empty;
	assign head = entry_q[rd_ptr_q];
	assign stat = '{level: level_q};

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + LVL_W'(push.n) - LVL_W'(do_pop);
		end
	end

endmodule

>>> design/life_generation_row_stream.sv
// One generation of Life (birth on three neighbours, survival on two or three)
// over a grid that streams in one row per transaction, top row first.
// The slave channel (s_tvalid, s_tready, s_tdata, s_tlast) takes one row per
// transaction; s_tlast marks the bottom row. The master channel returns rows
// of the new generation in order; m_tlast marks its bottom row.
// Each row after the first releases the next state of the row before it; the
// bottom row also releases its own, so it gives two transactions. A single-row
// grid gives one. The cfg channel writes row_width; columns at or beyond it
// are dead. Write it only between transactions; the block does not check.
// A result is registered in the result queue as its row is taken.
// A row is taken in every cycle while the four-entry result queue has two
// entries free; the queue takes a row only then, so that the bottom row of
// each grid, which gives two results, always fits.
// When the receiver stalls the queue fills and s_tready falls; nothing is lost.
// Reset clears the held rows, empties the queue and sets row_width to 64.
module life_generation_row_stream
	import lgrs_pkg::*;
#(
	parameter int MAX_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ROW_BITS-1:0]   s_tdata,   // row_cells[63:0]
	input  logic                  s_tlast,   // last_row
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ROW_BITS-1:0]   m_tdata,   // next_row_cells[63:0]
	output logic                  m_tlast,   // last_out
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIDTH_BITS-1:0] cfg_data   // row_width[6:0]
);

	localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);

	logic [WIDTH_BITS-1:0] width_q;
	logic [WIDTH_BITS-1:0] width_sat;
	logic held_q;
	logic s_accept;
	logic [MAX_WIDTH-1:0] col_en;
	logic [MAX_WIDTH-1:0] mid_bits;
	logic [MAX_WIDTH-1:0] last_bits;
	nb_t nb [MAX_WIDTH];
	result_t res_mid;
	result_t res_last;
	push_t push;
	result_t head;
	queue_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	// A width above the number of cells saturates.
	assign width_sat = (width_q > MAX_W) ? MAX_W : width_q;

	// Two free queue entries are kept so that a bottom row always fits.
	assign s_tready = (q_stat.level <= LVL_W'(QUEUE_DEPTH - 2));
	assign s_accept = s_tvalid & s_tready;

	// Whether a row is pending; the bottom row returns the block to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (s_accept) begin
			held_q <= ~s_tlast;
		end
	end

	// One cell per column. Each sees the masked bits of the columns on either
	// side; the outermost cells see dead columns beyond the edge.
	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_col
		nb_t nb_l;
		nb_t nb_r;

		assign col_en[k] = (WIDTH_BITS'(k) < width_sat);

		if (k == 0) begin : g_left_edge
			assign nb_l = '0;
		end else begin : g_left
			assign nb_l = nb[k-1];
		end

		if (k == MAX_WIDTH - 1) begin : g_right_edge
			assign nb_r = '0;
		end else begin : g_right
			assign nb_r = nb[k+1];
		end

		lgrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.col_en   (col_en[k]),
			.in_bit   (s_tdata[k]),
			.acc      (s_accept),
			.last     (s_tlast),
			.held     (held_q),
			.nb_left  (nb_l),
			.nb_right (nb_r),
			.nb_own   (nb[k]),
			.res_mid  (mid_bits[k]),
			.res_last (last_bits[k])
		);
	end

	assign res_mid = '{cells: ROW_BITS'(mid_bits), last: 1'b0};
	assign res_last = '{cells: ROW_BITS'(last_bits), last: 1'b1};

	// The row before comes out first, then the bottom row if this is it.
	always_comb begin
		push.n = 2'd0;
		push.r0 = res_mid;
		push.r1 = res_last;
		if (s_accept) begin
			push.n = 2'(held_q) + 2'(s_tlast);
			if (!held_q) begin
				push.r0 = res_last;
			end
		end
	end

	lgrs_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.stat      (q_stat)
	);

	assign m_tdata = head.cells;
	assign m_tlast = head.last;

	// The queue never holds more than it has room for.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= LVL_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// After the bottom row no row is left pending.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tlast) |=> !held_q)
		else $error("row still pending after bottom row");

	// Any other row stays pending.
	a_row_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !s_tlast) |=> held_q)
		else $error("row not held after transaction");

	// An accepted row always adds at least one result unless it starts a grid.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && held_q) |=> (q_stat.level != '0))
		else $error("result missing after row");

endmodule
